### src/cti_pkg.sv
package cti_pkg;

    // Store dimensions
    localparam int MAX_TIMES      = 64;
    localparam int MAX_COVARIATES = 8;
    localparam int ROW_W          = $clog2(MAX_TIMES);
    localparam int COL_W          = $clog2(MAX_COVARIATES);
    localparam int SADDR_W        = ROW_W + COL_W;

    // Field and register widths
    localparam int TIMES_W  = 7;
    localparam int COVS_W   = 4;
    localparam int TARGET_W = 8;
    localparam int VALUE_W  = 32;
    localparam int IN_W     = 56;
    localparam int OUT_W    = 40;
    localparam int CFGI_W   = 2;
    localparam int CFGD_W   = 7;
    localparam int BIT_W    = $clog2(VALUE_W);

    // Configuration register indexes
    localparam logic [CFGI_W-1:0] CFG_TIMES = 2'd0;
    localparam logic [CFGI_W-1:0] CFG_COVS  = 2'd1;
    localparam logic [CFGI_W-1:0] CFG_HOLD  = 2'd2;

    // Input item kinds
    typedef enum logic [1:0] {
        FUNC_TIME,
        FUNC_SAMPLE,
        FUNC_MAP,
        FUNC_QUERY
    } t_func;

    // Time table read address source
    typedef enum logic [1:0] {
        TRD_FIRST,
        TRD_LAST,
        TRD_SCAN
    } t_trd;

    // Controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_T0_RD,
        S_T0_CMP,
        S_TN_RD,
        S_TN_CMP,
        S_SC_RD,
        S_SC_CMP,
        S_COL,
        S_RD_A,
        S_RD_B,
        S_LOAD_B,
        S_DIV,
        S_EMIT,
        S_WAIT
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic in_ready;
        t_trd trd;
        logic set_first;
        logic set_last;
        logic set_hit;
        logic set_pair;
        logic scan_init;
        logic scan_next;
        logic col_clear;
        logic col_next;
        logic s_sel_b;
        logic cap_lo;
        logic load_b;
        logic div_step;
        logic load_out;
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic in_query;
        logic any_mapped;
        logic t_le;
        logic t_ge;
        logic t_eq;
        logic t_gt;
        logic scan_end;
        logic cur_mapped;
        logic last_col;
        logic use_div;
        logic div_done;
        logic out_free;
    } t_sts;

endpackage

### src/cti_ctrl.sv
module cti_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  cti_pkg::t_sts i_sts,
    output cti_pkg::t_cmd o_cmd
);
    import cti_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (i_sts.in_query && i_sts.any_mapped) n_state = S_T0_RD;
            S_T0_RD:  n_state = S_T0_CMP;
            S_T0_CMP: n_state = i_sts.t_le ? S_COL : S_TN_RD;
            S_TN_RD:  n_state = S_TN_CMP;
            S_TN_CMP: n_state = i_sts.t_ge ? S_COL : S_SC_RD;
            S_SC_RD:  n_state = S_SC_CMP;
            S_SC_CMP: begin
                if (i_sts.t_gt || i_sts.t_eq || i_sts.scan_end) n_state = S_COL;
                else n_state = S_SC_RD;
            end
            S_COL:    if (i_sts.cur_mapped) n_state = S_RD_A;
            S_RD_A:   n_state = S_RD_B;
            S_RD_B:   n_state = S_LOAD_B;
            S_LOAD_B: n_state = i_sts.use_div ? S_DIV : S_EMIT;
            S_DIV:    if (i_sts.div_done) n_state = S_EMIT;
            S_EMIT:   n_state = S_WAIT;
            S_WAIT: begin
                if (i_sts.out_free) n_state = i_sts.last_col ? S_IDLE : S_COL;
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // Command outputs
    always_comb begin
        o_cmd = '0;
        o_cmd.trd = TRD_FIRST;
        case (r_state)
            S_IDLE: begin
                o_cmd.in_ready  = 1'b1;
                o_cmd.col_clear = 1'b1;
            end
            S_T0_RD:  o_cmd.trd = TRD_FIRST;
            S_T0_CMP: o_cmd.set_first = i_sts.t_le;
            S_TN_RD:  o_cmd.trd = TRD_LAST;
            S_TN_CMP: begin
                o_cmd.set_last  = i_sts.t_ge;
                o_cmd.scan_init = !i_sts.t_ge;
            end
            S_SC_RD:  o_cmd.trd = TRD_SCAN;
            S_SC_CMP: begin
                if (i_sts.t_gt) o_cmd.set_pair = 1'b1;
                else if (i_sts.t_eq) o_cmd.set_hit = 1'b1;
                else if (i_sts.scan_end) o_cmd.set_last = 1'b1;
                else o_cmd.scan_next = 1'b1;
            end
            S_COL:    o_cmd.col_next = !i_sts.cur_mapped;
            S_RD_A:   o_cmd.s_sel_b = 1'b0;
            S_RD_B: begin
                o_cmd.s_sel_b = 1'b1;
                o_cmd.cap_lo  = 1'b1;
            end
            S_LOAD_B: o_cmd.load_b = 1'b1;
            S_DIV:    o_cmd.div_step = 1'b1;
            S_EMIT:   o_cmd.load_out = 1'b1;
            S_WAIT:   o_cmd.col_next = i_sts.out_free && !i_sts.last_col;
            default:  o_cmd = '0;
        endcase
    end

    // The output register is empty whenever a new item may enter.
    a_idle_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> i_sts.out_free)
        else $error("idle with a result still pending");

    // The divider only runs for an interpolated pair.
    a_div_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> i_sts.use_div)
        else $error("division without an interpolation pair");

    // Column search only runs when some column is mapped.
    a_col_mapped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COL) |-> i_sts.any_mapped)
        else $error("column search with no mapped column");

endmodule

### src/cti_dp.sv
module cti_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  cti_pkg::t_cmd                 i_cmd,
    output cti_pkg::t_sts                 o_sts,
    input  logic                          i_s_tvalid,
    input  logic [cti_pkg::IN_W-1:0]      i_s_tdata,
    input  logic [1:0]                    i_s_tuser,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [cti_pkg::OUT_W-1:0]     o_m_tdata,
    output logic                          o_m_tlast,
    input  logic                          i_cfg_valid,
    input  logic [cti_pkg::CFGI_W-1:0]    i_cfg_index,
    input  logic [cti_pkg::CFGD_W-1:0]    i_cfg_data
);
    import cti_pkg::*;

    // Memories
    logic [VALUE_W-1:0]  time_mem [MAX_TIMES];
    logic [VALUE_W-1:0]  samp_mem [MAX_TIMES*MAX_COVARIATES];
    logic [TARGET_W-1:0] r_map    [MAX_COVARIATES];

    logic [TIMES_W-1:0] r_times;
    logic [COVS_W-1:0]  r_covs;
    logic               r_hold;

    logic signed [VALUE_W-1:0] r_t;
    logic signed [VALUE_W-1:0] r_tdata;
    logic signed [VALUE_W-1:0] r_tprev;
    logic signed [VALUE_W-1:0] r_sdata;
    logic signed [VALUE_W-1:0] r_ylo;
    logic [ROW_W-1:0]   r_idx;
    logic [ROW_W-1:0]   r_row_a;
    logic [ROW_W-1:0]   r_row_b;
    logic               r_pair;
    logic [COL_W-1:0]   r_col;
    logic [VALUE_W:0]   r_dx;
    logic [VALUE_W:0]   r_dt;
    logic [VALUE_W-1:0] r_mag;
    logic               r_neg;
    logic [VALUE_W-1:0] r_q;
    logic [VALUE_W:0]   r_rem;
    logic [BIT_W-1:0]   r_bit;
    logic               r_out_valid;
    logic [TARGET_W-1:0] r_out_param;
    logic [VALUE_W-1:0] r_out_value;
    logic               r_out_last;

    // Input unpacking
    t_func                     w_func;
    logic [ROW_W-1:0]          w_row;
    logic [COL_W-1:0]          w_column;
    logic [TARGET_W-1:0]       w_target;
    logic [VALUE_W-1:0]        w_value;
    logic                      w_take;

    assign w_func   = t_func'(i_s_tuser);
    assign w_row    = i_s_tdata[5:0];
    assign w_column = i_s_tdata[8:6];
    assign w_target = i_s_tdata[16:9];
    assign w_value  = i_s_tdata[48:17];
    assign w_take   = i_s_tvalid && i_cmd.in_ready;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_times <= TIMES_W'(1);
            r_covs  <= '0;
            r_hold  <= 1'b0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_TIMES) r_times <= i_cfg_data[TIMES_W-1:0];
            if (i_cfg_index == CFG_COVS) r_covs <= i_cfg_data[COVS_W-1:0];
            if (i_cfg_index == CFG_HOLD) r_hold <= i_cfg_data[0];
        end
    end

    // Effective time count minus one and column count
    logic [ROW_W-1:0]  w_nm1;
    logic [COVS_W-1:0] w_ncol;
    always_comb begin
        if (r_times == '0) w_nm1 = '0;
        else if (r_times > TIMES_W'(MAX_TIMES)) w_nm1 = ROW_W'(MAX_TIMES - 1);
        else w_nm1 = ROW_W'(r_times - TIMES_W'(1));
        if (r_covs > COVS_W'(MAX_COVARIATES)) w_ncol = COVS_W'(MAX_COVARIATES);
        else w_ncol = r_covs;
    end

    // Mapped-column mask and the last-column flag for the current column
    logic [MAX_COVARIATES-1:0] w_mask;
    logic                      w_above;
    always_comb begin
        w_above = 1'b0;
        for (int c = 0; c < MAX_COVARIATES; c++) begin
            w_mask[c] = (COVS_W'(c) < w_ncol) && (r_map[c] != '0);
            if (c > int'(r_col) && w_mask[c]) w_above = 1'b1;
        end
    end

    // Map entries, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < MAX_COVARIATES; c++) r_map[c] <= '0;
        end else if (w_take && w_func == FUNC_MAP) begin
            r_map[w_column] <= w_target;
        end
    end

    // Time table: write on transfer, registered read
    logic [ROW_W-1:0] w_taddr;
    always_comb begin
        case (i_cmd.trd)
            TRD_FIRST: w_taddr = '0;
            TRD_LAST:  w_taddr = w_nm1;
            TRD_SCAN:  w_taddr = r_idx;
            default:   w_taddr = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_take && w_func == FUNC_TIME) time_mem[w_row] <= w_value;
        r_tdata <= time_mem[w_taddr];
    end

    // Sample store: write on transfer, registered read
    logic [SADDR_W-1:0] w_saddr;
    assign w_saddr = {r_col, (i_cmd.s_sel_b ? r_row_b : r_row_a)};

    always_ff @(posedge i_clk) begin
        if (w_take && w_func == FUNC_SAMPLE) samp_mem[{w_column, w_row}] <= w_value;
        r_sdata <= samp_mem[w_saddr];
    end

    // Query time, bracket search and column pointer
    always_ff @(posedge i_clk) begin
        if (w_take && w_func == FUNC_QUERY) r_t <= w_value;
        if (i_cmd.scan_init) r_idx <= '0;
        if (i_cmd.scan_next) begin
            r_idx   <= r_idx + ROW_W'(1);
            r_tprev <= r_tdata;
        end
        if (i_cmd.set_first) begin
            r_row_a <= '0;
            r_row_b <= '0;
            r_pair  <= 1'b0;
        end
        if (i_cmd.set_last) begin
            r_row_a <= w_nm1;
            r_row_b <= w_nm1;
            r_pair  <= 1'b0;
        end
        if (i_cmd.set_hit) begin
            r_row_a <= r_idx;
            r_row_b <= r_idx;
            r_pair  <= 1'b0;
        end
        if (i_cmd.set_pair) begin
            r_row_a <= r_idx - ROW_W'(1);
            r_row_b <= r_idx;
            r_pair  <= 1'b1;
            r_dx    <= {r_t[VALUE_W-1], r_t} - {r_tprev[VALUE_W-1], r_tprev};
            r_dt    <= {r_tdata[VALUE_W-1], r_tdata} - {r_tprev[VALUE_W-1], r_tprev};
        end
        if (i_cmd.col_clear) r_col <= '0;
        else if (i_cmd.col_next) r_col <= r_col + COL_W'(1);
    end

    // Difference of the two samples and the shift-add scaling unit
    logic signed [VALUE_W:0] w_dy;
    logic [VALUE_W+2:0]      w_rem1;
    logic [VALUE_W+2:0]      w_rem2;
    logic [VALUE_W+2:0]      w_rem3;
    logic [1:0]              w_qinc;
    assign w_dy = {r_sdata[VALUE_W-1], r_sdata} - {r_ylo[VALUE_W-1], r_ylo};

    always_comb begin
        w_qinc = 2'd0;
        w_rem1 = {1'b0, r_rem, 1'b0} +
                 (r_mag[VALUE_W-1] ? {2'b00, r_dx} : '0);
        w_rem2 = w_rem1;
        if (w_rem1 >= {2'b00, r_dt}) begin
            w_rem2 = w_rem1 - {2'b00, r_dt};
            w_qinc = 2'd1;
        end
        w_rem3 = w_rem2;
        if (w_rem2 >= {2'b00, r_dt}) begin
            w_rem3 = w_rem2 - {2'b00, r_dt};
            w_qinc = 2'd2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_lo) r_ylo <= r_sdata;
        if (i_cmd.load_b) begin
            r_neg <= w_dy[VALUE_W];
            r_mag <= w_dy[VALUE_W] ? VALUE_W'(-w_dy) : w_dy[VALUE_W-1:0];
            r_q   <= '0;
            r_rem <= '0;
            r_bit <= BIT_W'(VALUE_W - 1);
        end else if (i_cmd.div_step) begin
            r_mag <= {r_mag[VALUE_W-2:0], 1'b0};
            r_q   <= {r_q[VALUE_W-2:0], 1'b0} + VALUE_W'(w_qinc);
            r_rem <= w_rem3[VALUE_W:0];
            r_bit <= r_bit - BIT_W'(1);
        end
    end

    // Result assembly with saturation
    logic signed [VALUE_W+1:0] w_sum;
    logic [VALUE_W-1:0]        w_sat;
    always_comb begin
        if (r_neg) w_sum = {{2{r_ylo[VALUE_W-1]}}, r_ylo} - {2'b00, r_q};
        else w_sum = {{2{r_ylo[VALUE_W-1]}}, r_ylo} + {2'b00, r_q};
        if (w_sum > $signed({3'b000, {(VALUE_W-1){1'b1}}})) begin
            w_sat = {1'b0, {(VALUE_W-1){1'b1}}};
        end else if (w_sum < $signed({3'b111, {(VALUE_W-1){1'b0}}})) begin
            w_sat = {1'b1, {(VALUE_W-1){1'b0}}};
        end else begin
            w_sat = w_sum[VALUE_W-1:0];
        end
    end

    // Output register; a result is held until its transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_param <= r_map[r_col] - TARGET_W'(1);
            r_out_value <= w_sat;
            r_out_last  <= !w_above;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_value, r_out_param};
    assign o_m_tlast  = r_out_last;

    // Status to the controller
    always_comb begin
        o_sts.in_query   = i_s_tvalid && (w_func == FUNC_QUERY);
        o_sts.any_mapped = |w_mask;
        o_sts.t_le       = r_t <= r_tdata;
        o_sts.t_ge       = r_t >= r_tdata;
        o_sts.t_eq       = r_t == r_tdata;
        o_sts.t_gt       = r_tdata > r_t;
        o_sts.scan_end   = r_idx == w_nm1;
        o_sts.cur_mapped = w_mask[r_col];
        o_sts.last_col   = !w_above;
        o_sts.use_div    = r_pair && !r_hold;
        o_sts.div_done   = r_bit == '0;
        o_sts.out_free   = !r_out_valid;
    end

endmodule

### src/covariate_time_interpolator_unit.sv
// Channel     Direction  Ports                         Contents
// s (items)   in         i_s_tvalid/o_s_tready         tuser func, tdata row..value
// m (results) out        o_m_tvalid/i_m_tready         tdata param_index, result_value
// cfg         in         i_cfg_valid/o_cfg_ready       index 0..2, data
//
// A query checks the time table end points, then scans the time entries, then
// skips each unmapped column and, per mapped column, reads two samples and runs
// the shift-add scaling unit when interpolating; output stalls hold it back.
// Reset is synchronous and active low; it clears map, config, state and output valid.
// The next item is taken only after every result of a query has been transferred.
module covariate_time_interpolator_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // Fields from bit 0: row[5:0], column[8:6], target[16:9], value[48:17], zeros
    input  logic [cti_pkg::IN_W-1:0]      i_s_tdata,
    // Fields from bit 0: func[1:0]
    input  logic [1:0]                    i_s_tuser,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // Fields from bit 0: param_index[7:0], result_value[39:8]
    output logic [cti_pkg::OUT_W-1:0]     o_m_tdata,
    output logic                          o_m_tlast,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [cti_pkg::CFGI_W-1:0]    i_cfg_index,
    input  logic [cti_pkg::CFGD_W-1:0]    i_cfg_data
);
    import cti_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    // Configuration writes are always taken.
    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = w_cmd.in_ready;

    // Sequencer
    cti_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    // Stores, search and arithmetic
    cti_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_s_tvalid  (i_s_tvalid),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

endmodule
